/* hdl/lfu_pkg.sv */
package lfu_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int KEY_BITS_DEF   = 32;
  localparam int VALUE_BITS_DEF = 32;
  localparam int COUNT_BITS     = 32;
  localparam int CAP_BITS       = 5;
  localparam int CAP_RESET      = 16;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef struct packed {
    logic dec_en;
    logic touch_en;
    logic wr_val;
    logic kill_en;
    logic ins_en;
  } lfu_cmd_t;

endpackage

/* hdl/lfu_cell.sv */
module lfu_cell #(
  parameter int INDEX      = 0,
  parameter int IDX_W      = 4,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  lfu_pkg::lfu_cmd_t     cmd,
  input  logic [IDX_W-1:0]      tgt_idx,
  input  logic [IDX_W-1:0]      ins_idx,
  input  logic [IDX_W-1:0]      kill_idx,
  input  logic [IDX_W-1:0]      dec_rank,
  input  logic [IDX_W-1:0]      new_rank,
  input  logic [KEY_BITS-1:0]   wkey,
  input  logic [VALUE_BITS-1:0] wval,
  input  logic [KEY_BITS-1:0]   lkey,
  output logic                  valid,
  output logic                  match,
  output logic [KEY_BITS-1:0]   key,
  output logic [VALUE_BITS-1:0] value,
  output logic [IDX_W-1:0]      rank,
  input  logic                  cin_ok,
  input  logic [lfu_pkg::COUNT_BITS-1:0] cin_cnt,
  input  logic [IDX_W-1:0]      cin_rank,
  input  logic [IDX_W-1:0]      cin_idx,
  output logic                  cout_ok,
  output logic [lfu_pkg::COUNT_BITS-1:0] cout_cnt,
  output logic [IDX_W-1:0]      cout_rank,
  output logic [IDX_W-1:0]      cout_idx
);
  import lfu_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

  logic [COUNT_BITS-1:0] count;
  logic                  take;

  assign match = valid && (key == lkey);
  assign take  = valid && (!cin_ok || count < cin_cnt ||
                           (count == cin_cnt && rank < cin_rank));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      cout_ok <= 1'b0;
    end else begin
      cout_ok <= cin_ok || valid;
      if (cmd.ins_en && ins_idx == MY_IDX) valid <= 1'b1;
      else if (cmd.kill_en && kill_idx == MY_IDX) valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cout_cnt  <= count;
      cout_rank <= rank;
      cout_idx  <= MY_IDX;
    end else begin
      cout_cnt  <= cin_cnt;
      cout_rank <= cin_rank;
      cout_idx  <= cin_idx;
    end
    if (cmd.dec_en && valid && rank > dec_rank) rank <= rank - 1'b1;
    if (cmd.touch_en && tgt_idx == MY_IDX) begin
      rank <= new_rank;
      if (count != '1) count <= count + 1'b1;
      if (cmd.wr_val) value <= wval;
    end
    if (cmd.ins_en && ins_idx == MY_IDX) begin
      rank  <= new_rank;
      count <= COUNT_BITS'(1);
      key   <= wkey;
      value <= wval;
    end
  end

endmodule

/* hdl/lfu_cache_table.sv */
// LFU key/value table with LRU tie break.
// Input channel s_*: tuser = opcode (0 get, 1 put), tdata = lookup_key then
// store_value. Output channel m_*: one response per request, tdata = hit,
// read_value, evicted, evicted_key.
// Config: cfg_wen/cfg_wdata write the capacity register; the user must do so
// only while idle, the block does not enforce it. A request passes accept,
// lookup and the output register to a result, except a put of a new key into
// a full table: the victim search runs through the row of entry cells one
// cell a cycle, then the victim is replaced. One request is in flight at a
// time; s_tready is high only when idle, so a new request is taken only once the last is done.
// If m_tready is low the finished response waits in its output register
// and the next request is not taken until that register can be loaded.
// rst (synchronous) clears all entries and sets capacity to 16.
module lfu_cache_table #(
  parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
  parameter int KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = lfu_pkg::VALUE_BITS_DEF,
  localparam int IN_W  = ((KEY_BITS + VALUE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 + KEY_BITS + VALUE_BITS + 7) / 8) * 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [IN_W-1:0]              s_tdata,   // lookup_key, store_value
  input  logic                         s_tuser,   // opcode
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [OUT_W-1:0]             m_tdata,   // hit, read_value, evicted, evicted_key
  input  logic                         cfg_wen,
  input  logic [lfu_pkg::CAP_BITS-1:0] cfg_wdata
);
  import lfu_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {S_IDLE, S_LOOK, S_SCAN, S_APPLY, S_DONE} state_t;

  state_t                state;
  logic [CAP_BITS-1:0]   capacity;
  logic [OCC_W-1:0]      occ;
  logic [OCC_W-1:0]      scan_cnt;
  logic                  op;
  logic [KEY_BITS-1:0]   lkey;
  logic [VALUE_BITS-1:0] lval;
  logic                  res_hit;
  logic [VALUE_BITS-1:0] res_val;
  logic                  res_ev;
  logic [KEY_BITS-1:0]   res_key;

  lfu_cmd_t              cmd;
  logic [IDX_W-1:0]      tgt_idx, ins_idx, kill_idx, dec_rank, new_rank;

  logic [ENTRIES-1:0]    c_valid, c_match;
  logic [KEY_BITS-1:0]   c_key   [ENTRIES];
  logic [VALUE_BITS-1:0] c_value [ENTRIES];
  logic [IDX_W-1:0]      c_rank  [ENTRIES];
  logic                  ch_ok   [ENTRIES+1];
  logic [COUNT_BITS-1:0] ch_cnt  [ENTRIES+1];
  logic [IDX_W-1:0]      ch_rank [ENTRIES+1];
  logic [IDX_W-1:0]      ch_idx  [ENTRIES+1];

  logic                  found, ff_ok, need_evict, cap_zero;
  logic [IDX_W-1:0]      found_idx, ff_idx, vic_idx;
  logic [31:0]           cap_eff;

  assign ch_ok[0]   = 1'b0;
  assign ch_cnt[0]  = '0;
  assign ch_rank[0] = '0;
  assign ch_idx[0]  = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lfu_cell #(
      .INDEX(i), .IDX_W(IDX_W), .KEY_BITS(KEY_BITS), .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk, .rst, .cmd, .tgt_idx, .ins_idx, .kill_idx, .dec_rank, .new_rank,
      .wkey(lkey), .wval(lval), .lkey,
      .valid(c_valid[i]), .match(c_match[i]), .key(c_key[i]),
      .value(c_value[i]), .rank(c_rank[i]),
      .cin_ok(ch_ok[i]), .cin_cnt(ch_cnt[i]), .cin_rank(ch_rank[i]),
      .cin_idx(ch_idx[i]),
      .cout_ok(ch_ok[i+1]), .cout_cnt(ch_cnt[i+1]), .cout_rank(ch_rank[i+1]),
      .cout_idx(ch_idx[i+1])
    );
  end

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    ff_ok     = 1'b0;
    ff_idx    = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (c_match[i]) begin
        found     = 1'b1;
        found_idx = IDX_W'(i);
      end
      if (!c_valid[i]) begin
        ff_ok  = 1'b1;
        ff_idx = IDX_W'(i);
      end
    end
  end

  assign vic_idx    = ch_idx[ENTRIES];
  assign cap_zero   = (capacity == '0);
  assign cap_eff    = (32'(capacity) > 32'(ENTRIES)) ? 32'(ENTRIES) : 32'(capacity);
  assign need_evict = (32'(occ) >= cap_eff);

  always_comb begin
    cmd      = '0;
    tgt_idx  = found_idx;
    kill_idx = vic_idx;
    ins_idx  = ff_idx;
    dec_rank = c_rank[found_idx];
    new_rank = IDX_W'(occ - 1'b1);
    case (state)
      S_LOOK: begin
        if (found && (op == OP_GET || !cap_zero)) begin
          cmd.dec_en   = 1'b1;
          cmd.touch_en = 1'b1;
          cmd.wr_val   = (op == OP_PUT);
        end else if (op == OP_PUT && !found && !cap_zero && !need_evict) begin
          cmd.ins_en = 1'b1;
          new_rank   = IDX_W'(occ);
        end
      end
      S_APPLY: begin
        cmd.dec_en  = 1'b1;
        cmd.kill_en = 1'b1;
        cmd.ins_en  = 1'b1;
        dec_rank    = ch_rank[ENTRIES];
        ins_idx     = (ff_ok && ff_idx < vic_idx) ? ff_idx : vic_idx;
      end
      default: ;
    endcase
  end

  assign s_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      capacity <= CAP_BITS'(CAP_RESET);
      occ      <= '0;
      scan_cnt <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_wen) capacity <= cfg_wdata;
      if (m_tvalid && m_tready && state != S_DONE) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op    <= s_tuser;
            lkey  <= s_tdata[KEY_BITS-1:0];
            lval  <= s_tdata[KEY_BITS +: VALUE_BITS];
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          res_hit <= found;
          res_val <= (found && op == OP_GET) ? c_value[found_idx] : '0;
          res_ev  <= 1'b0;
          res_key <= '0;
          state   <= S_DONE;
          if (cmd.ins_en) occ <= occ + 1'b1;
          if (op == OP_PUT && !found && !cap_zero && need_evict) begin
            scan_cnt <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_cnt <= scan_cnt + 1'b1;
          if (scan_cnt == OCC_W'(ENTRIES)) state <= S_APPLY;
        end
        S_APPLY: begin
          res_ev  <= 1'b1;
          res_key <= c_key[vic_idx];
          state   <= S_DONE;
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_W'({res_key, res_ev, res_val, res_hit});
            state    <= S_IDLE;
          end else if (m_tvalid && m_tready) begin
            m_tvalid <= 1'b0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
